### rtl/u8ncpd_pkg.sv
// Shared types and constants of the UTF-8 n-th code point decoder.
// No dependencies; imported by utf8_nth_code_point_decoder.
package u8ncpd_pkg;

    typedef logic [20:0] t_code;
    typedef logic [2:0]  t_seq_len;

    // Characters returned in place of a code point
    localparam t_code CODE_BAD   = 21'd63;   // '?'
    localparam t_code CODE_SPACE = 21'd32;   // ' '

    // Sequence lengths given by the lead byte
    localparam t_seq_len SEQ_NONE = 3'd0;
    localparam t_seq_len SEQ_ONE  = 3'd1;
    localparam t_seq_len SEQ_TWO  = 3'd2;
    localparam t_seq_len SEQ_THREE = 3'd3;
    localparam t_seq_len SEQ_FOUR = 3'd4;

    // Length of the sequence that a lead byte opens, SEQ_NONE if it opens none
    function automatic t_seq_len lead_len(input logic [7:0] lead);
        t_seq_len len;
        if (lead[7] == 1'b0) begin
            len = SEQ_ONE;
        end else if (lead[7:5] == 3'b110) begin
            len = SEQ_TWO;
        end else if (lead[7:4] == 4'b1110) begin
            len = SEQ_THREE;
        end else if (lead[7:3] == 5'b11110) begin
            len = SEQ_FOUR;
        end else begin
            len = SEQ_NONE;
        end
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

### rtl/utf8_nth_code_point_decoder.sv
// A word in the input register is decoded in the single pass between the input register and
// the result register, which captures its result only for the word that ends a string; the
// whole resync over at most three held bytes and the new byte is settled in that pass.
// Throughput: one byte word per cycle; a string's last word waits on a full, stalled result.
// Reset (i_rst_n, synchronous, active low): both registers empty, no bytes held,
// position count zero, next byte starts a new string. No clearing pass.
//
// Top level of the UTF-8 n-th code point decoder.
// Depends on u8ncpd_pkg (constants, lead-byte decoding).
module utf8_nth_code_point_decoder #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte words
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    input  logic [15:0] i_wanted_position,
    // result words
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic        o_found
);
    import u8ncpd_pkg::*;

    // ---------------------------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------------------------
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;
    logic [15:0] r_in_wanted;

    // ---------------------------------------------------------------------------------------
    // Per-string decode state
    // ---------------------------------------------------------------------------------------
    logic [7:0]               r_pend [3];     // bytes of an unfinished sequence
    logic [1:0]               r_pend_cnt;
    logic [POSITION_BITS-1:0] r_seen;         // code points decoded so far
    logic [POSITION_BITS-1:0] r_target;
    logic                     r_hit;
    t_code                    r_held;
    logic                     r_stopped;
    logic                     r_first;

    // Result register
    logic                     r_out_valid;
    t_code                    r_out_code;
    logic                     r_out_found;

    // Handshake: a word that ends a string needs the result register free (or being
    // drained this cycle); other words always move on.
    logic advance;
    assign advance = r_in_valid && (!r_in_end || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    // ---------------------------------------------------------------------------------------
    // Decode pass: held bytes plus the new byte, at most four bytes, hence at most four
    // passes of the resync loop; each pass emits at most one code point.
    // ---------------------------------------------------------------------------------------
    logic [31:0]              c_target_ext;
    logic [POSITION_BITS-1:0] c_target;
    logic [POSITION_BITS-1:0] c_seen_plus [5];
    logic [31:0]              c_vec;         // first byte in the top lane
    logic [2:0]               c_cnt;
    logic [2:0]               c_emits;
    logic                     c_stop;
    logic                     c_brk;
    logic                     c_hit;
    t_code                    c_held;
    logic [7:0]               c_lead;
    t_seq_len                 c_need;
    t_seq_len                 c_used;
    logic                     c_bad;
    t_code                    c_code;
    logic [7:0]               c_b [1:3];
    logic [POSITION_BITS-1:0] n_seen;
    logic [1:0]               n_pend_cnt;

    assign c_target_ext = {16'd0, r_in_wanted};
    assign c_target = r_first ? c_target_ext[POSITION_BITS-1:0] : r_target;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            c_seen_plus[k] = r_seen + POSITION_BITS'(k);
        end

        // Append the new byte behind the held ones
        c_vec = 32'd0;
        unique case (r_pend_cnt)
            2'd0: c_vec = {r_in_byte, 24'd0};
            2'd1: c_vec = {r_pend[0], r_in_byte, 16'd0};
            2'd2: c_vec = {r_pend[0], r_pend[1], r_in_byte, 8'd0};
            2'd3: c_vec = {r_pend[0], r_pend[1], r_pend[2], r_in_byte};
            default: c_vec = 32'd0;
        endcase
        c_cnt   = {1'b0, r_pend_cnt} + 3'd1;
        c_emits = 3'd0;
        c_stop  = r_stopped;
        c_brk   = 1'b0;
        c_hit   = r_hit;
        c_held  = r_held;
        c_lead  = 8'd0;
        c_need  = SEQ_NONE;
        c_used  = SEQ_ONE;
        c_bad   = 1'b0;
        c_code  = CODE_BAD;
        for (int j = 1; j < 4; j++) begin
            c_b[j] = 8'd0;
        end

        for (int it = 0; it < 4; it++) begin
            if (c_cnt != 3'd0 && !c_stop && !c_brk) begin
                c_lead = c_vec[31:24];
                c_b[1] = c_vec[23:16];
                c_b[2] = c_vec[15:8];
                c_b[3] = c_vec[7:0];
                if (c_lead == 8'd0) begin
                    // zero byte: stop decoding for the rest of the string
                    c_stop = 1'b1;
                    c_cnt  = 3'd0;
                end else begin
                    c_need = lead_len(c_lead);
                    c_bad  = (c_need == SEQ_NONE);
                    for (int i = 1; i < 4; i++) begin
                        if (3'(i) < c_need && 3'(i) < c_cnt && !is_cont(c_b[i])) begin
                            c_bad = 1'b1;
                        end
                    end
                    if (!c_bad && c_cnt < c_need) begin
                        // incomplete: hold, unless the string ends here
                        if (!r_in_end) begin
                            c_brk = 1'b1;
                        end else begin
                            c_bad = 1'b1;
                        end
                    end
                    if (!c_brk) begin
                        c_used = c_bad ? SEQ_ONE : c_need;
                        c_code = CODE_BAD;
                        if (!c_bad) begin
                            unique case (c_need)
                                SEQ_ONE:   c_code = {13'd0, c_lead};
                                SEQ_TWO:   c_code = {10'd0, c_lead[4:0], c_b[1][5:0]};
                                SEQ_THREE: c_code = {5'd0, c_lead[3:0], c_b[1][5:0],
                                                     c_b[2][5:0]};
                                SEQ_FOUR:  c_code = {c_lead[2:0], c_b[1][5:0],
                                                     c_b[2][5:0], c_b[3][5:0]};
                                default:   c_code = CODE_BAD;
                            endcase
                        end
                        if (!c_hit && c_seen_plus[c_emits] == c_target) begin
                            c_hit  = 1'b1;
                            c_held = c_code;
                            c_stop = 1'b1;
                        end
                        c_emits = c_emits + 3'd1;
                        c_vec   = c_vec << {c_used, 3'b000};
                        c_cnt   = c_cnt - c_used;
                    end
                end
            end
        end
        if (c_stop) begin
            c_cnt = 3'd0;
        end
        n_seen     = c_seen_plus[c_emits];
        n_pend_cnt = c_cnt[1:0];
    end

    // ---------------------------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte   <= i_data_byte;
            r_in_end    <= i_end_of_string;
            r_in_wanted <= i_wanted_position;
        end
    end

    // Held bytes: only entries below the count are ever read
    always_ff @(posedge i_clk) begin
        if (advance && !r_stopped) begin
            r_pend[0] <= c_vec[31:24];
            r_pend[1] <= c_vec[23:16];
            r_pend[2] <= c_vec[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
            r_seen     <= '0;
            r_target   <= '0;
            r_hit      <= 1'b0;
            r_held     <= CODE_SPACE;
            r_stopped  <= 1'b0;
            r_first    <= 1'b1;
        end else if (advance) begin
            if (r_in_end) begin
                // string done: return to the idle per-string state
                r_pend_cnt <= 2'd0;
                r_seen     <= '0;
                r_target   <= '0;
                r_hit      <= 1'b0;
                r_held     <= CODE_SPACE;
                r_stopped  <= 1'b0;
                r_first    <= 1'b1;
            end else begin
                r_target <= c_target;
                r_first  <= 1'b0;
                if (!r_stopped) begin
                    r_pend_cnt <= n_pend_cnt;
                    r_seen     <= n_seen;
                    r_hit      <= c_hit;
                    r_held     <= c_held;
                    r_stopped  <= c_stop;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // A stopped string keeps its earlier hit; otherwise take this pass's outcome
    always_ff @(posedge i_clk) begin
        if (advance && r_in_end) begin
            r_out_code  <= c_hit ? c_held : CODE_SPACE;
            r_out_found <= c_hit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_out_code;
    assign o_found      = r_out_found;

`ifndef SYNTHESIS
    // An absent position always reads as a space
    a_absent_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_code == CODE_SPACE)
        else $error("result without hit is not a space");

    // A stopped string holds no bytes
    a_stop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> r_pend_cnt == 2'd0)
        else $error("bytes held after decoding stopped");

    // A hit always stops decoding
    a_hit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_stopped)
        else $error("hit without stop");

    // The end of a string clears the per-string state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_end |=> r_first && !r_hit && r_pend_cnt == 2'd0 && r_out_valid)
        else $error("string end did not clear state");

    // Upstream is held only for a waiting word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_in_end && r_out_valid && i_stall)
        else $error("stall without a blocked end word");
`endif

endmodule
